// ===== rtl/spdcm_pkg.sv =====
// Shared types and constants for the side pattern dedup and culling matrix block.
// Holds the controller state enum and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spdcm_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned ROW_W   = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned MROW_W  = 64;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 80;

  // Result kinds carried in the output tuser.
  localparam logic KIND_SIDE   = 1'b0;
  localparam logic KIND_MATRIX = 1'b1;

  // Input functions carried in the input tuser.
  localparam logic FUNC_ROW    = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PAD,
    ST_FIND,
    ST_SIDE_OUT,
    ST_FIN_NEXT,
    ST_FIN_A,
    ST_FIN_AW,
    ST_FIN_SCAN,
    ST_FIN_OUT
  } spdcm_state_t;

  typedef struct packed {
    logic row_accept;
    logic fin_start;
    logic sp_clr;
    logic scan_run;
    logic scan_fin;
    logic pad_load;
    logic find_step;
    logic side_emit;
    logic fin_next;
    logic fin_a_read;
    logic fin_a_cap;
    logic row_step;
    logic fin_emit;
    logic fin_clear;
  } spdcm_cmd_t;

  typedef struct packed {
    logic in_func;
    logic in_last_row;
    logic room;
    logic last_row_q;
    logic scan_done;
    logic find_stop;
    logic fin_end;
    logic fin_nonempty;
    logic row_end;
    logic out_free;
  } spdcm_sts_t;

endpackage
`default_nettype wire

// ===== rtl/spdcm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module spdcm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/spdcm_ctrl.sv =====
// Controller state machine for the side pattern dedup block.
// Depends on spdcm_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module spdcm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire spdcm_pkg::spdcm_sts_t sts,
  output spdcm_pkg::spdcm_cmd_t    cmd
);

  spdcm_pkg::spdcm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spdcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spdcm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (sts.in_func == spdcm_pkg::FUNC_FINISH) begin
            state_next = spdcm_pkg::ST_FIN_NEXT;
          end else if (sts.room) begin
            state_next = spdcm_pkg::ST_SCAN;
          end else if (sts.in_last_row) begin
            state_next = spdcm_pkg::ST_FIND;
          end
        end
      end
      spdcm_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          if (!sts.last_row_q) begin
            state_next = spdcm_pkg::ST_IDLE;
          end else if (sts.room) begin
            state_next = spdcm_pkg::ST_PAD;
          end else begin
            state_next = spdcm_pkg::ST_FIND;
          end
        end
      end
      spdcm_pkg::ST_PAD:  state_next = spdcm_pkg::ST_SCAN;
      spdcm_pkg::ST_FIND: begin
        if (sts.find_stop) begin
          state_next = spdcm_pkg::ST_SIDE_OUT;
        end
      end
      spdcm_pkg::ST_SIDE_OUT: begin
        if (sts.out_free) begin
          state_next = spdcm_pkg::ST_IDLE;
        end
      end
      spdcm_pkg::ST_FIN_NEXT: begin
        if (sts.fin_end) begin
          state_next = spdcm_pkg::ST_IDLE;
        end else if (!sts.fin_nonempty) begin
          state_next = spdcm_pkg::ST_FIN_OUT;
        end else begin
          state_next = spdcm_pkg::ST_FIN_A;
        end
      end
      spdcm_pkg::ST_FIN_A:  state_next = spdcm_pkg::ST_FIN_AW;
      spdcm_pkg::ST_FIN_AW: state_next = spdcm_pkg::ST_FIN_SCAN;
      spdcm_pkg::ST_FIN_SCAN: begin
        if (sts.scan_done) begin
          state_next = sts.row_end ? spdcm_pkg::ST_FIN_OUT : spdcm_pkg::ST_FIN_A;
        end
      end
      spdcm_pkg::ST_FIN_OUT: begin
        if (sts.out_free) begin
          state_next = spdcm_pkg::ST_FIN_NEXT;
        end
      end
      default: state_next = spdcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      spdcm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (sts.in_func == spdcm_pkg::FUNC_FINISH) begin
            cmd.fin_start = 1'b1;
          end else begin
            cmd.row_accept = 1'b1;
          end
        end
      end
      spdcm_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done && sts.last_row_q && !sts.room) begin
          cmd.sp_clr = 1'b1;
        end
      end
      spdcm_pkg::ST_PAD:  cmd.pad_load  = 1'b1;
      spdcm_pkg::ST_FIND: cmd.find_step = 1'b1;
      spdcm_pkg::ST_SIDE_OUT: cmd.side_emit = sts.out_free;
      spdcm_pkg::ST_FIN_NEXT: begin
        cmd.fin_next  = 1'b1;
        cmd.fin_clear = sts.fin_end;
      end
      spdcm_pkg::ST_FIN_A:  cmd.fin_a_read = 1'b1;
      spdcm_pkg::ST_FIN_AW: cmd.fin_a_cap  = 1'b1;
      spdcm_pkg::ST_FIN_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_fin = 1'b1;
        cmd.row_step = sts.scan_done && !sts.row_end;
      end
      spdcm_pkg::ST_FIN_OUT: cmd.fin_emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/spdcm_dp.sv =====
// Datapath of the side pattern dedup block: pattern store, match and subset
// vectors, counters and the output register. Depends on spdcm_pkg and spdcm_ram.
`timescale 1ns / 1ps
`default_nettype none
module spdcm_dp #(
  parameter int unsigned RASTER_WIDTH = 32,
  parameter int unsigned MAX_PATTERNS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [spdcm_pkg::S_DATA_W-1:0]       s_tdata,
  input  wire logic                                 s_tuser,
  input  wire logic                                 s_tlast,
  input  wire spdcm_pkg::spdcm_cmd_t                cmd,
  output spdcm_pkg::spdcm_sts_t                     sts,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [spdcm_pkg::M_DATA_W-1:0]            m_tdata,
  output logic                                      m_tuser,
  output logic                                      m_tlast
);

  localparam int unsigned COLS   = (RASTER_WIDTH < 32) ? RASTER_WIDTH : 32;
  localparam int unsigned RW_W   = $clog2(RASTER_WIDTH);
  localparam int unsigned RCNT_W = $clog2(RASTER_WIDTH + 1);
  localparam int unsigned PI_W   = $clog2(MAX_PATTERNS);
  localparam int unsigned CNT_W  = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned DEPTH  = MAX_PATTERNS * RASTER_WIDTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [COLS-1:0] ONES = '1;

  logic [RCNT_W-1:0]       row_cnt;
  logic [RW_W-1:0]         cur_r;
  logic [COLS-1:0]         cur_row;
  logic [COLS-1:0]         a_row;
  logic [CNT_W-1:0]        pcount;
  logic [CNT_W-1:0]        sp;
  logic [CNT_W-1:0]        fj;
  logic                    rd_v;
  logic [PI_W-1:0]         rd_p;
  logic [MAX_PATTERNS-1:0] miss;
  logic [MAX_PATTERNS-1:0] notsub;
  logic [MAX_PATTERNS-1:0] nonempty;
  logic                    ones_acc;
  logic                    nz_acc;
  logic                    last_row_q;
  logic                    last_side_q;
  logic [PI_W-1:0]         full_idx;
  logic                    full_known;
  logic                    type_all_full;

  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;
  logic [COLS-1:0]         rdata;
  logic [COLS-1:0]         in_row;
  logic                    room;
  logic                    has_slot;
  logic                    found;
  logic                    ovf;
  logic [PI_W-1:0]         idx;
  logic                    fk_new;
  logic [PI_W-1:0]         fidx_new;
  logic                    taf_new;
  logic [CNT_W-1:0]        pcount_new;
  logic [MAX_PATTERNS-1:0] valid_mask;
  logic [MAX_PATTERNS-1:0] mrow;
  logic                    out_free;

  assign in_row   = s_tdata[COLS-1:0];
  assign room     = row_cnt < RCNT_W'(RASTER_WIDTH);
  assign has_slot = pcount < CNT_W'(MAX_PATTERNS);
  assign out_free = !m_tvalid || m_tready;

  // The side under construction is written straight into the next free slot;
  // it only becomes a pattern when the count moves past it.
  assign we    = cmd.scan_run && !cmd.scan_fin && has_slot;
  assign waddr = ADDR_W'(pcount[PI_W-1:0]) * ADDR_W'(RASTER_WIDTH) + ADDR_W'(cur_r);
  assign raddr = cmd.fin_a_read
               ? ADDR_W'(fj[PI_W-1:0]) * ADDR_W'(RASTER_WIDTH) + ADDR_W'(cur_r)
               : ADDR_W'(sp[PI_W-1:0]) * ADDR_W'(RASTER_WIDTH) + ADDR_W'(cur_r);

  spdcm_ram #(.WIDTH(COLS), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cur_row),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Side decision, valid while the finder has stopped.
  assign found      = sp < pcount;
  assign ovf        = !found && !has_slot;
  assign idx        = found ? sp[PI_W-1:0] : (has_slot ? pcount[PI_W-1:0] : '0);
  assign fk_new     = full_known || (!ovf && ones_acc);
  assign fidx_new   = full_known ? full_idx : idx;
  assign taf_new    = type_all_full && !ovf && fk_new && (idx == fidx_new);
  assign pcount_new = (!found && !ovf) ? pcount + CNT_W'(1) : pcount;

  always_comb begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      valid_mask[i] = CNT_W'(i) < pcount;
    end
    mrow = nonempty[fj[PI_W-1:0]] ? (~notsub & valid_mask) : '0;
  end

  always_comb begin
    sts              = '0;
    sts.in_func      = s_tuser;
    sts.in_last_row  = s_tlast;
    sts.room         = room;
    sts.last_row_q   = last_row_q;
    sts.scan_done    = (sp == pcount) && !rd_v;
    sts.find_stop    = (sp == pcount) || !miss[sp[PI_W-1:0]];
    sts.fin_end      = fj == pcount;
    sts.fin_nonempty = nonempty[fj[PI_W-1:0]];
    sts.row_end      = cur_r == RW_W'(RASTER_WIDTH - 1);
    sts.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt       <= '0;
      pcount        <= '0;
      sp            <= '0;
      fj            <= '0;
      rd_v          <= 1'b0;
      miss          <= '0;
      nonempty      <= '0;
      ones_acc      <= 1'b1;
      nz_acc        <= 1'b0;
      last_row_q    <= 1'b0;
      full_idx      <= '0;
      full_known    <= 1'b0;
      type_all_full <= 1'b1;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.scan_run) begin
        rd_v <= sp < pcount;
        if (sp < pcount) begin
          sp <= sp + CNT_W'(1);
        end
      end else begin
        rd_v <= 1'b0;
      end
      if (rd_v && !cmd.scan_fin) begin
        miss[rd_p] <= miss[rd_p] | (rdata != cur_row);
      end

      if (cmd.row_accept) begin
        last_row_q <= s_tlast;
        sp         <= '0;
        if (room) begin
          row_cnt  <= row_cnt + RCNT_W'(1);
          ones_acc <= ones_acc && (in_row == ONES);
          nz_acc   <= nz_acc || (in_row != '0);
        end
      end
      if (cmd.pad_load) begin
        row_cnt  <= row_cnt + RCNT_W'(1);
        ones_acc <= 1'b0;
        sp       <= '0;
      end
      if (cmd.sp_clr || cmd.fin_a_cap) begin
        sp <= '0;
      end
      if (cmd.find_step && !sts.find_stop) begin
        sp <= sp + CNT_W'(1);
      end

      if (cmd.side_emit) begin
        if (!found && !ovf) begin
          nonempty[pcount[PI_W-1:0]] <= nz_acc;
        end
        pcount        <= pcount_new;
        full_known    <= fk_new;
        full_idx      <= fidx_new;
        type_all_full <= last_side_q ? 1'b1 : taf_new;
        row_cnt       <= '0;
        ones_acc      <= 1'b1;
        nz_acc        <= 1'b0;
        miss          <= '0;
      end

      if (cmd.fin_start) begin
        fj <= '0;
      end
      if (cmd.fin_emit) begin
        fj <= fj + CNT_W'(1);
      end
      if (cmd.fin_clear) begin
        pcount        <= '0;
        nonempty      <= '0;
        full_known    <= 1'b0;
        full_idx      <= '0;
        type_all_full <= 1'b1;
        row_cnt       <= '0;
        ones_acc      <= 1'b1;
        nz_acc        <= 1'b0;
        miss          <= '0;
      end

      if (cmd.side_emit || cmd.fin_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.row_accept) begin
      last_side_q <= s_tdata[spdcm_pkg::ROW_W];
      if (room) begin
        cur_row <= in_row;
        cur_r   <= row_cnt[RW_W-1:0];
      end
    end
    if (cmd.pad_load) begin
      cur_row <= '0;
      cur_r   <= row_cnt[RW_W-1:0];
    end
    if (cmd.fin_next) begin
      cur_r  <= '0;
      notsub <= '0;
    end
    if (cmd.row_step) begin
      cur_r <= cur_r + RW_W'(1);
    end
    if (cmd.fin_a_cap) begin
      a_row <= rdata;
    end
    if (rd_v && cmd.scan_fin) begin
      notsub[rd_p] <= notsub[rd_p] | ((a_row & ~rdata) != '0);
    end
    rd_p <= sp[PI_W-1:0];

    if (cmd.side_emit) begin
      m_tuser <= spdcm_pkg::KIND_SIDE;
      m_tlast <= 1'b0;
      m_tdata <= {spdcm_pkg::TOTAL_W'(pcount_new), spdcm_pkg::MROW_W'(0), ovf,
                  last_side_q && taf_new, last_side_q, spdcm_pkg::IDX_W'(idx)};
    end
    if (cmd.fin_emit) begin
      m_tuser <= spdcm_pkg::KIND_MATRIX;
      m_tlast <= (fj + CNT_W'(1)) == pcount;
      m_tdata <= {spdcm_pkg::TOTAL_W'(pcount), spdcm_pkg::MROW_W'(mrow), 3'b000,
                  spdcm_pkg::IDX_W'(fj)};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/side_pattern_dedup_and_cull_matrix.sv =====
// Top level of the side pattern dedup and culling matrix block.
// Depends on spdcm_pkg, spdcm_ctrl, spdcm_dp and spdcm_ram.
//
// Usage: side bitmaps arrive on the input stream one row word at a time
// (tuser = 0), tlast marking the final row of a side and tdata bit 32 the
// final side of a voxel type. Each closed side yields one output word with
// the pattern index it was matched to or stored as, and at a type's end the
// full occluder flag. A finish word (tuser = 1) yields one culling matrix row
// per stored pattern, tlast on the final one, and then empties the table.
// Each row word that fits is compared with the same row of every stored
// pattern, paced by the one-pattern-per-cycle read port of the pattern store.
// Closing a side pads and compares each row not given as a zero row, then
// searches for the match and loads the result into the output register. A
// finish tests each row of each nonempty stored pattern against that row of
// every stored pattern, each subset test reading one stored row per cycle.
// Reset empties the table and resets its flags; the store needs no clearing
// pass since only entries below the pattern count are read.
// An output register separates the two sides: a new word is taken while a
// result waits, and a stalled receiver only holds the block when the next
// result is ready to be loaded.
`timescale 1ns / 1ps
`default_nettype none
module side_pattern_dedup_and_cull_matrix #(
  parameter int unsigned RASTER_WIDTH = 32,
  parameter int unsigned MAX_PATTERNS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // row_bits [31:0], last_side [32], zero fill [39:33]
  input  wire logic [39:0] s_tdata,
  // func [0]
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // pat_index [5:0], type_done [6], full_occluder [7], overflow [8],
  // matrix_row [72:9], pattern_total [79:73]
  output logic [79:0]      m_tdata,
  // kind [0]
  output logic             m_tuser,
  output logic             m_tlast
);

  spdcm_pkg::spdcm_cmd_t cmd;
  spdcm_pkg::spdcm_sts_t sts;

  // The controller sequences row scans, padding, the match search and the
  // finish passes; the datapath owns all storage.
  spdcm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  spdcm_dp #(
    .RASTER_WIDTH(RASTER_WIDTH),
    .MAX_PATTERNS(MAX_PATTERNS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .cmd     (cmd),
    .sts     (sts),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/spdcm_checker.sv =====
// Port-level checker for the side pattern dedup block, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module spdcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic [79:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // A matrix row never carries side flags.
  a_matrix_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[8:6] == 3'b000)
    else $error("matrix row carries side flags");

  // A side result never carries a matrix row or an end mark.
  a_side_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tlast && m_tdata[72:9] == 64'd0)
    else $error("side result carries matrix data");

  // Full occluder is only reported where a type closes.
  a_full_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7] || m_tdata[6])
    else $error("full occluder without type end");

  // An overflowed side reports index zero and a nonzero table count.
  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[5:0] == 6'd0 && m_tdata[79:73] != 7'd0)
    else $error("overflow result with bad index or count");

endmodule

bind side_pattern_dedup_and_cull_matrix spdcm_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
`default_nettype wire

// ===== tb/spdcm_checker.sv =====
// Scoreboard for the side pattern dedup and culling matrix block.
// Watches both stream channels, predicts the results and compares them.
// Depends on spdcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spdcm_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [79:0] m_tdata,
  input  wire logic        m_tuser,
  input  wire logic        m_tlast,
  output int               fail_count,
  output int               pending
);

  localparam int ROWS = 32;
  localparam int SLOTS = 64;

  typedef struct packed {
    logic                          kind;
    logic [spdcm_pkg::IDX_W-1:0]   idx;
    logic                          done;
    logic                          full;
    logic                          ovf;
    logic [spdcm_pkg::MROW_W-1:0]  mrow;
    logic [spdcm_pkg::TOTAL_W-1:0] total;
    logic                          last;
  } result_t;

  result_t expected_q[$];

  logic [ROWS-1:0] table_rows [SLOTS][ROWS];
  logic [ROWS-1:0] side_rows [ROWS];
  logic            slot_nonempty [SLOTS];
  int              rows_in;
  int              slot_count;
  int              full_slot;
  logic            full_known;
  logic            type_full;

  task automatic clear_table();
    for (int r = 0; r < ROWS; r++) side_rows[r] = '0;
    for (int p = 0; p < SLOTS; p++) slot_nonempty[p] = 1'b0;
    rows_in = 0;
    slot_count = 0;
    full_slot = 0;
    full_known = 1'b0;
    type_full = 1'b1;
  endtask

  function automatic logic covers(int sub, int sup);
    for (int r = 0; r < ROWS; r++)
      if ((table_rows[sub][r] & ~table_rows[sup][r]) != '0) return 1'b0;
    return 1'b1;
  endfunction

  // Emit one matrix row per stored pattern, then empty the table.
  task automatic predict_finish();
    result_t res;
    for (int j = 0; j < slot_count; j++) begin
      res = '0;
      res.kind = spdcm_pkg::KIND_MATRIX;
      res.idx = j[spdcm_pkg::IDX_W-1:0];
      res.total = slot_count[spdcm_pkg::TOTAL_W-1:0];
      res.last = (j + 1 == slot_count);
      if (slot_nonempty[j])
        for (int i = 0; i < slot_count; i++)
          if (covers(j, i)) res.mrow[i] = 1'b1;
      expected_q.insert(expected_q.size(), res);
    end
    clear_table();
  endtask

  // Take one row word; at the final row look the side up in the table.
  task automatic predict_row(logic [ROWS-1:0] bits, logic end_row, logic end_type);
    result_t res;
    logic found, ovf, all_ones, nonempty, same;
    int hit;
    found = 1'b0;
    ovf = 1'b0;
    all_ones = 1'b1;
    nonempty = 1'b0;
    hit = 0;
    if (rows_in < ROWS) begin
      side_rows[rows_in] = bits;
      rows_in++;
    end
    if (end_row) begin
      for (int r = 0; r < ROWS; r++) begin
        if (side_rows[r] != '1) all_ones = 1'b0;
        if (side_rows[r] != '0) nonempty = 1'b1;
      end
      for (int p = 0; p < slot_count && !found; p++) begin
        same = 1'b1;
        for (int r = 0; r < ROWS; r++)
          if (table_rows[p][r] != side_rows[r]) same = 1'b0;
        if (same) begin
          found = 1'b1;
          hit = p;
        end
      end
      if (!found) begin
        if (slot_count < SLOTS) begin
          hit = slot_count;
          for (int r = 0; r < ROWS; r++) table_rows[hit][r] = side_rows[r];
          slot_nonempty[hit] = nonempty;
          slot_count++;
        end else begin
          ovf = 1'b1;
          hit = 0;
        end
      end
      if (!ovf && !full_known && all_ones) begin
        full_known = 1'b1;
        full_slot = hit;
      end
      if (ovf || !full_known || hit != full_slot) type_full = 1'b0;
      res = '0;
      res.kind = spdcm_pkg::KIND_SIDE;
      res.idx = hit[spdcm_pkg::IDX_W-1:0];
      res.done = end_type;
      res.full = end_type && type_full;
      res.ovf = ovf;
      res.total = slot_count[spdcm_pkg::TOTAL_W-1:0];
      expected_q.insert(expected_q.size(), res);
      if (end_type) type_full = 1'b1;
      for (int r = 0; r < ROWS; r++) side_rows[r] = '0;
      rows_in = 0;
    end
  endtask

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch in %s: expected %h, got %h", field, want, got);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result word %h", m_tdata);
      return;
    end
    want = expected_q.pop_front();
    if (m_tuser != want.kind) note_mismatch("kind", want.kind, m_tuser);
    if (m_tdata[5:0] != want.idx) note_mismatch("pat_index", want.idx, m_tdata[5:0]);
    if (m_tdata[6] != want.done) note_mismatch("type_done", want.done, m_tdata[6]);
    if (m_tdata[7] != want.full) note_mismatch("full_occluder", want.full, m_tdata[7]);
    if (m_tdata[8] != want.ovf) note_mismatch("overflow", want.ovf, m_tdata[8]);
    if (m_tdata[72:9] != want.mrow) note_mismatch("matrix_row", want.mrow, m_tdata[72:9]);
    if (m_tdata[79:73] != want.total)
      note_mismatch("pattern_total", want.total, m_tdata[79:73]);
    if (m_tlast != want.last) note_mismatch("last", want.last, m_tlast);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_table();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == spdcm_pkg::FUNC_FINISH) predict_finish();
        else predict_row(s_tdata[31:0], s_tlast, s_tdata[32]);
      end
      if (m_tvalid && m_tready) check_result();
    end
    pending = expected_q.size();
  end

endmodule
`default_nettype wire

// ===== tb/side_pattern_dedup_and_cull_matrix_test.sv =====
// Testbench top for the side pattern dedup and culling matrix block.
// Drives side bitmaps and finish words and gives the verdict; depends on
// spdcm_pkg, spdcm_scoreboard and the block itself.
`timescale 1ns / 1ps
`default_nettype none
module side_pattern_dedup_and_cull_matrix_test;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending;
  int word_count;
  int cycle_count;
  int idle_pct;
  int stall_pct;
  logic [31:0] row_pool [8];

  side_pattern_dedup_and_cull_matrix u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  spdcm_scoreboard u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // A stuck block must not hang the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one word. The sender may first go idle, then it holds the word until
  // the block takes it at a rising edge. All changes happen at the falling
  // edge, so the rising edge sees stable inputs.
  task automatic send_word(logic func, logic [31:0] bits, logic end_row,
                           logic end_type);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = func;
    s_tdata = {7'd0, end_type, bits};
    s_tlast = end_row;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    word_count++;
  endtask

  // A side of the given number of rows, every row taken from one value.
  // The type-end flag rides only on the final row; on the others it is
  // random, since the block must ignore it there.
  task automatic send_flat_side(int rows, logic [31:0] bits, logic end_type);
    for (int r = 0; r < rows; r++)
      send_word(spdcm_pkg::FUNC_ROW, bits, r == rows - 1,
                (r == rows - 1) ? end_type : 1'($urandom_range(1)));
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_row();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return row_pool[$urandom_range(7)];
    endcase
  endfunction

  // One random side: mostly a few rows drawn from a small pool so that
  // duplicates and subsets are common, sometimes a full or overlong side.
  task automatic send_random_side();
    int rows;
    logic end_type;
    end_type = ($urandom_range(99) < 40);
    case ($urandom_range(19))
      0: send_flat_side(32, 32'hFFFF_FFFF, end_type);
      1: begin
        rows = $urandom_range(32, 35);
        for (int r = 0; r < rows; r++)
          send_word(spdcm_pkg::FUNC_ROW, pick_row(), r == rows - 1, end_type);
      end
      default: begin
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
          send_word(spdcm_pkg::FUNC_ROW, pick_row(), r == rows - 1, end_type);
      end
    endcase
  endtask

  task automatic random_phase(int idle, int stall, int words);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = word_count + words;
    while (word_count < stop_at) begin
      case ($urandom_range(11))
        0: send_word(spdcm_pkg::FUNC_FINISH, $urandom(), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        // A side cut short by a finish is abandoned.
        1: begin
          send_word(spdcm_pkg::FUNC_ROW, pick_row(), 1'b0, 1'b0);
          send_word(spdcm_pkg::FUNC_FINISH, 32'h0, 1'b0, 1'b0);
        end
        default: send_random_side();
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = spdcm_pkg::FUNC_ROW;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cycle_count = 0;
    word_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int k = 0; k < 8; k++) row_pool[k] = $urandom() & $urandom();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. A finish on the empty table gives nothing; a full side
    // closing its type is a full occluder; an empty short side, a single
    // set bit, and an overlong side whose extra rows are dropped.
    send_word(spdcm_pkg::FUNC_FINISH, 32'h0, 1'b1, 1'b1);
    send_flat_side(32, 32'hFFFF_FFFF, 1'b1);
    send_word(spdcm_pkg::FUNC_ROW, 32'h0, 1'b1, 1'b1);
    send_word(spdcm_pkg::FUNC_ROW, 32'h8000_0001, 1'b1, 1'b0);
    send_word(spdcm_pkg::FUNC_ROW, 32'h0000_0001, 1'b1, 1'b1);
    send_flat_side(34, 32'hFFFF_FFFF, 1'b1);
    send_word(spdcm_pkg::FUNC_FINISH, 32'hFFFF_FFFF, 1'b0, 1'b0);
    drain();

    // Fill the table past capacity so the overflow path is taken, and let
    // a finish report the full matrix.
    for (int k = 0; k < 66; k++)
      send_word(spdcm_pkg::FUNC_ROW,
                (k < 32) ? (32'h1 << k) : ~(32'h1 << (k - 32)), 1'b1,
                (k % 3) == 2);
    send_flat_side(32, 32'hFFFF_FFFF, 1'b1);
    send_word(spdcm_pkg::FUNC_FINISH, 32'h0, 1'b0, 1'b0);

    // Random part in phases of sender and receiver idling. After the
    // first phase the sender holds off until every result is back.
    random_phase(0, 0, 50);
    drain();
    random_phase(82, 0, 50);
    random_phase(0, 82, 50);
    random_phase(34, 34, 50);
    send_word(spdcm_pkg::FUNC_FINISH, 32'h0, 1'b0, 1'b0);

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
